// File: rtl/core/rf_sector_detection_confirmer_macros.svh
// ----------------------------------------------------------------------------
// RF sector detection confirmer: assertion macros
// Shared property wrappers for the port checker. All use clk and rst.
// ----------------------------------------------------------------------------
`ifndef RF_SECTOR_DETECTION_CONFIRMER_MACROS_SVH
`define RF_SECTOR_DETECTION_CONFIRMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rsdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdc_pkg
// Widths, constants, payload and control types for the sector confirmer.
// ----------------------------------------------------------------------------
package rsdc_pkg;

  // Field widths
  localparam int FREQ_W   = 16;
  localparam int RSSI_W   = 20;
  localparam int NOISE_W  = 20;
  localparam int KURT_W   = 16;
  localparam int SCORE_W  = 31;
  localparam int COUNT_W  = 4;
  localparam int CONF_W   = 7;
  localparam int DECAY_W  = 8;
  localparam int STREAK_W = 8;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;

  // Algorithm constants
  localparam int STREAK_UNIT    = 16;
  localparam int KURTOSIS_SCALE = 256;
  localparam int SECTOR_COUNT   = 3;
  localparam int SECTOR_W       = 2;
  localparam int ENERGY_SHIFT   = 10;
  localparam int DIVIDEND_W     = RSSI_W + ENERGY_SHIFT;
  localparam int DIV_CNT_W      = $clog2(DIVIDEND_W);
  localparam int KURT_BASE      = 3 * KURTOSIS_SCALE;
  localparam int KURT_GAIN      = 256;
  localparam int KTERM_W        = KURT_W + 8;
  localparam int CONF_FULL      = 3072;
  localparam int CONF_FULL_W    = $clog2(CONF_FULL);
  localparam int CONF_MAX       = 100;
  localparam int CONF_PRE_W     = 9;
  localparam int DIV3_MUL       = 171;
  localparam int DIV3_SHIFT     = 9;
  localparam int CNT_FULL_W     = COUNT_W + 1;

  localparam logic [FREQ_W-1:0] FREQ_SECTOR0 = 16'd5745;
  localparam logic [FREQ_W-1:0] FREQ_SECTOR1 = 16'd5785;
  localparam logic [FREQ_W-1:0] FREQ_SECTOR2 = 16'd5825;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd2;

  // Register reset values
  localparam logic [SCORE_W-1:0] THRESHOLD_RST = 31'd2048;
  localparam logic [COUNT_W-1:0] CONFIRM_RST   = 4'd3;
  localparam logic [DECAY_W-1:0] DECAY_RST     = 8'd8;

  typedef struct packed {
    logic [FREQ_W-1:0]  carrier_mhz;
    logic [RSSI_W-1:0]  rssi_level;
    logic [NOISE_W-1:0] noise_floor;
    logic [KURT_W-1:0]  kurtosis;
  } sample_t;

  typedef struct packed {
    logic               detected;
    logic [FREQ_W-1:0]  freq_echo;
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] streak_level;
    logic [CONF_W-1:0]  confidence;
  } result_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic sum;
    logic scale;
    logic write;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

// File: rtl/core/rsdc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdc_datapath
// Restoring divider, score/confidence stages, sector streaks, config regs.
// ----------------------------------------------------------------------------
module rsdc_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rsdc_pkg::dp_cmd_t                      cmd,
  output rsdc_pkg::dp_status_t                   status,
  input  rsdc_pkg::sample_t                      sample,
  output rsdc_pkg::result_t                      result,
  input  logic                                   cfg_we,
  input  logic [rsdc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rsdc_pkg::CFG_W-1:0]             cfg_data
);
  import rsdc_pkg::*;

  // Config registers
  logic [SCORE_W-1:0] score_threshold;
  logic [COUNT_W-1:0] confirm_required;
  logic [DECAY_W-1:0] streak_decay;

  // Divider
  logic [DIVIDEND_W-1:0] quot;
  logic [NOISE_W-1:0]    rem;
  logic [NOISE_W-1:0]    divisor;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [NOISE_W:0]      rem_sh;
  logic [NOISE_W:0]      rem_diff;
  logic                  rem_ge;

  // Item context
  logic [FREQ_W-1:0]   freq;
  logic [SECTOR_W-1:0] sector;
  logic [KTERM_W-1:0]  kterm;
  logic [SECTOR_W-1:0] sector_next;
  logic [KTERM_W-1:0]  kterm_next;

  // Score stages
  logic [SCORE_W-1:0]        score;
  logic                      hit;
  logic                      conf_sat;
  logic [CONF_PRE_W-1:0]     conf_pre;
  logic [CONF_FULL_W+6:0]    conf_prod;

  // Streaks
  logic [STREAK_W-1:0] streaks [SECTOR_COUNT];
  logic [STREAK_W-1:0] st_cur;
  logic [STREAK_W:0]   st_cap;
  logic [STREAK_W-1:0] streak_next;
  logic [STREAK_W:0]   st_round;
  logic [CNT_FULL_W-1:0] count_full;
  logic [CONF_PRE_W+7:0] conf_q_prod;
  logic [CONF_W-1:0]   conf_val;

  // Sector select and kurtosis excess at load
  always_comb begin
    priority if (sample.carrier_mhz == FREQ_SECTOR1) begin
      sector_next = SECTOR_W'(1);
    end else if (sample.carrier_mhz == FREQ_SECTOR2) begin
      sector_next = SECTOR_W'(2);
    end else begin
      sector_next = SECTOR_W'(0);
    end
    if (32'(sample.kurtosis) > 32'(KURT_BASE)) begin
      kterm_next = KTERM_W'(((32'(sample.kurtosis) - 32'(KURT_BASE)) * 32'(KURT_GAIN))
                            / KURTOSIS_SCALE);
    end else begin
      kterm_next = '0;
    end
  end

  // One quotient bit per step
  assign rem_sh   = {rem, quot[DIVIDEND_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign status.div_last = div_cnt == DIV_CNT_W'(DIVIDEND_W - 1);

  assign conf_prod = score[CONF_FULL_W-1:0] * 7'(CONF_MAX);

  // Streak update
  always_comb begin
    st_cur = streaks[sector];
    st_cap = (STREAK_W + 1)'(confirm_required) * (STREAK_W + 1)'(STREAK_UNIT);
    if (hit) begin
      if ({1'b0, st_cur} < st_cap) begin
        streak_next = st_cur + STREAK_W'(STREAK_UNIT);
      end else begin
        streak_next = st_cur;
      end
    end else begin
      streak_next = (st_cur > streak_decay) ? (st_cur - streak_decay) : '0;
    end
    st_round   = {1'b0, streak_next} + (STREAK_W + 1)'(STREAK_UNIT - 1);
    count_full = CNT_FULL_W'(st_round / STREAK_UNIT);
    // Floor divide by three for values below 300
    conf_q_prod = conf_pre * 8'(DIV3_MUL);
    conf_val    = conf_sat ? CONF_W'(CONF_MAX) : CONF_W'(conf_q_prod >> DIV3_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold  <= THRESHOLD_RST;
      confirm_required <= CONFIRM_RST;
      streak_decay     <= DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: score_threshold  <= cfg_data[SCORE_W-1:0];
        CFG_CONFIRM:   confirm_required <= cfg_data[COUNT_W-1:0];
        CFG_DECAY:     streak_decay     <= cfg_data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SECTOR_COUNT; i++) begin
        streaks[i] <= '0;
      end
    end else if (cmd.write) begin
      streaks[sector] <= streak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq    <= sample.carrier_mhz;
      sector  <= sector_next;
      kterm   <= kterm_next;
      quot    <= {sample.rssi_level, ENERGY_SHIFT'(0)};
      divisor <= (sample.noise_floor == '0) ? NOISE_W'(1) : sample.noise_floor;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.step) begin
      rem     <= rem_ge ? rem_diff[NOISE_W-1:0] : rem_sh[NOISE_W-1:0];
      quot    <= {quot[DIVIDEND_W-2:0], rem_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.sum) begin
      score <= SCORE_W'(quot) + SCORE_W'(kterm);
    end
    if (cmd.scale) begin
      hit      <= score >= score_threshold;
      conf_sat <= score >= SCORE_W'(CONF_FULL);
      conf_pre <= CONF_PRE_W'(conf_prod >> ENERGY_SHIFT);
    end
    if (cmd.write) begin
      result.detected      <= count_full >= CNT_FULL_W'(confirm_required);
      result.freq_echo     <= freq;
      result.score         <= score;
      result.streak_level  <= (count_full > CNT_FULL_W'({COUNT_W{1'b1}})) ?
                              {COUNT_W{1'b1}} : count_full[COUNT_W-1:0];
      result.confidence    <= conf_val;
    end
  end

endmodule

// File: rtl/core/rsdc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdc_ctrl
// Sequencer: accept, divide, sum, scale, write result; owns both handshakes.
// ----------------------------------------------------------------------------
module rsdc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  output logic                   result_valid,
  input  logic                   result_ready,
  output rsdc_pkg::dp_cmd_t      cmd,
  input  rsdc_pkg::dp_status_t   status
);
  import rsdc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   result_valid_next;
  logic   slot_free;

  assign slot_free = !result_valid || result_ready;

  always_comb begin
    state_next        = state;
    cmd               = '0;
    sample_ready      = 1'b0;
    result_valid_next = result_valid && !result_ready;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        // Wait here while the previous beat is still unclaimed
        if (slot_free) begin
          cmd.write         = 1'b1;
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

// File: rtl/core/rf_sector_detection_confirmer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_sector_detection_confirmer
// Scores RF samples, tracks a hit streak per sector and reports detection.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Dir  Beat
//  --------  -----------------------------------  ---  ------------------------
//  sample    sample_valid / sample_ready / sample  in   freq, rssi, noise, kurt
//  result    result_valid / result_ready / result  out  detect, freq, score, ...
//  cfg       cfg_we / cfg_index / cfg_data         in   one register write
//
//  A sample beat is taken only in idle; the energy term rssi*1024/noise
//  comes from a restoring divider that retires one quotient bit per cycle,
//  then the sum, scale and write steps follow in order.
//  The result register parts the two sides: a new sample is accepted while an
//  older result beat still waits; the write step stalls only if that older
//  beat is still unclaimed when the next result is ready.
//  Reset (rst, synchronous) clears the streaks, the sequencer and result_valid
//  and loads the register defaults; config writes are registered.
//
module rf_sector_detection_confirmer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  rsdc_pkg::sample_t                 sample,
  output logic                              result_valid,
  input  logic                              result_ready,
  output rsdc_pkg::result_t                 result,
  input  logic                              cfg_we,
  input  logic [rsdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsdc_pkg::CFG_W-1:0]        cfg_data
);
  import rsdc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: one item in flight, handshakes live here
  rsdc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  // Datapath: divider, score, confidence, streaks, registers
  rsdc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (sample),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// File: rtl/core/rsdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdc_checker
// Port-level checks for the sector confirmer, bound to the top level.
// ----------------------------------------------------------------------------
`include "rf_sector_detection_confirmer_macros.svh"

module rsdc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  input  logic                              sample_ready,
  input  logic                              result_valid,
  input  logic                              result_ready,
  input  rsdc_pkg::result_t                 result
);
  import rsdc_pkg::*;

  `RSDC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

  `RSDC_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready, "sample accepted while an item is in work")

  `RSDC_ASSERT_NOW(a_conf_range, result_valid, result.confidence <= CONF_W'(CONF_MAX), "confidence above full scale")

  `RSDC_ASSERT_NOW(a_conf_full, result_valid && (result.score >= SCORE_W'(CONF_FULL)), result.confidence == CONF_W'(CONF_MAX), "confidence not saturated at full score")

endmodule

bind rf_sector_detection_confirmer rsdc_checker u_rsdc_checker (.*);
